### src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/fet_pkg.sv
`default_nettype none

package fet_pkg;

	localparam int TOKEN_MAX_LEN = 255;
	localparam int LEN_W         = $clog2(TOKEN_MAX_LEN + 1);

	localparam int MAX_RECS  = 4;
	localparam int REC_IDX_W = $clog2(MAX_RECS);
	localparam int CNT_W     = $clog2(MAX_RECS + 1);

	localparam int BQ_DEPTH = 2;
	localparam int BQ_PTR_W = $clog2(BQ_DEPTH);
	localparam int BQ_CNT_W = $clog2(BQ_DEPTH + 1);

	localparam int OQ_DEPTH = 2;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic [3:0] KIND_EOF   = 4'd0;
	localparam logic [3:0] KIND_LP    = 4'd1;
	localparam logic [3:0] KIND_RP    = 4'd2;
	localparam logic [3:0] KIND_EQ    = 4'd3;
	localparam logic [3:0] KIND_NE    = 4'd4;
	localparam logic [3:0] KIND_GT    = 4'd5;
	localparam logic [3:0] KIND_GE    = 4'd6;
	localparam logic [3:0] KIND_LT    = 4'd7;
	localparam logic [3:0] KIND_LE    = 4'd8;
	localparam logic [3:0] KIND_AND   = 4'd9;
	localparam logic [3:0] KIND_OR    = 4'd10;
	localparam logic [3:0] KIND_NOT   = 4'd11;
	localparam logic [3:0] KIND_INT   = 4'd12;
	localparam logic [3:0] KIND_STR   = 4'd13;
	localparam logic [3:0] KIND_IDENT = 4'd14;
	localparam logic [3:0] KIND_ERR   = 4'd15;

	typedef enum logic [2:0] {
		LEX_IDLE,
		LEX_PEND,
		LEX_INT,
		LEX_IDENT,
		LEX_STR,
		LEX_ESC
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       ch_valid;
		logic       clause_end;
	} in_item_t;

	typedef struct packed {
		logic               is_text;
		logic [3:0]         kind;
		logic [7:0]         text_byte;
		logic signed [63:0] int_value;
		logic               int_saturated;
		logic [7:0]         text_length;
		logic               last;
	} out_item_t;

	// All results of one input item, oldest in recs[0].
	typedef struct packed {
		logic [CNT_W-1:0]             cnt;
		out_item_t [MAX_RECS-1:0]     recs;
	} bundle_t;

endpackage

`default_nettype wire

### src/fet_front.sv
`default_nettype none

module fet_front import fet_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire logic     full,
	input  wire in_item_t char_item,
	output logic          bq_push,
	output bundle_t       bq_wdata
);

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_LP    = 8'h28;
	localparam logic [7:0] CH_RP    = 8'h29;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LTT   = 8'h74;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [23:0] KW_AND = 24'h414E44;
	localparam logic [23:0] KW_OR  = 24'h4F5200;
	localparam logic [23:0] KW_NOT = 24'h4E4F54;

	// Largest magnitude that may still take one more digit is INT_T0 or one less.
	localparam logic signed [63:0] INT_T0    = 64'sd922337203685477580;
	localparam logic signed [63:0] INT_T0M1  = 64'sd922337203685477579;
	localparam logic signed [63:0] INT_MAX_V = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] INT_MIN_V = 64'sh8000_0000_0000_0000;

	function automatic out_item_t mk_rec(logic txt, logic [3:0] k, logic [7:0] byt,
			logic signed [63:0] iv, logic sat, logic [7:0] len);
		out_item_t r;
		r.is_text       = txt;
		r.kind          = k;
		r.text_byte     = byt;
		r.int_value     = iv;
		r.int_saturated = sat;
		r.text_length   = len;
		r.last          = 1'b0;
		return r;
	endfunction

	function automatic bundle_t bput(bundle_t b, out_item_t r);
		bundle_t nb;
		nb = b;
		if (nb.cnt < CNT_W'(MAX_RECS)) begin
			nb.recs[nb.cnt[REC_IDX_W-1:0]] = r;
			nb.cnt = nb.cnt + CNT_W'(1);
		end
		return nb;
	endfunction

	function automatic logic [7:0] len_sat(logic [LEN_W-1:0] l);
		if (l > LEN_W'(255))
			return 8'd255;
		else
			return 8'(l);
	endfunction

	function automatic out_item_t tok_rec(logic [3:0] k);
		return mk_rec(1'b0, k, 8'h00, 64'sd0, 1'b0, 8'h00);
	endfunction

	function automatic out_item_t flush_rec(logic [7:0] p);
		if (p == CH_GT)
			return tok_rec(KIND_GT);
		else if (p == CH_LT)
			return tok_rec(KIND_LT);
		else
			return mk_rec(1'b0, KIND_ERR, p, 64'sd0, 1'b0, 8'h00);
	endfunction

	function automatic out_item_t int_rec(logic signed [63:0] acc, logic neg, logic ovf);
		logic signed [63:0] v;
		if (ovf)
			v = neg ? INT_MIN_V : INT_MAX_V;
		else
			v = acc;
		return mk_rec(1'b0, KIND_INT, 8'h00, v, ovf, 8'h00);
	endfunction

	function automatic out_item_t ident_rec(logic [LEN_W-1:0] tl, logic [23:0] kwp);
		logic [3:0] k;
		if (tl == LEN_W'(3) && kwp == KW_AND)
			k = KIND_AND;
		else if (tl == LEN_W'(2) && kwp == KW_OR)
			k = KIND_OR;
		else if (tl == LEN_W'(3) && kwp == KW_NOT)
			k = KIND_NOT;
		else
			k = KIND_IDENT;
		return mk_rec(1'b0, k, 8'h00, 64'sd0, 1'b0, len_sat(tl));
	endfunction

	function automatic logic [3:0] cmp_kind(logic [7:0] p);
		logic [3:0] k;
		case (p)
			CH_EQ:   k = KIND_EQ;
			CH_BANG: k = KIND_NE;
			CH_GT:   k = KIND_GE;
			default: k = KIND_LE;
		endcase
		return k;
	endfunction

	// lexer state
	lex_mode_t          mode_q, mode_f;
	logic [7:0]         pend_q, pend_f;
	logic signed [63:0] acc_q, acc_f;
	logic               neg_q, neg_f;
	logic               ovf_q, ovf_f;
	logic [LEN_W-1:0]   tl_q, tl_f;
	logic [23:0]        kwp_q, kwp_f;

	logic               accept;
	logic [7:0]         c;
	logic               has_ch, end_item;
	logic               is_dig, is_alp, is_lower, is_idc, is_sp, is_op;
	logic [7:0]         upc, esc_c;
	logic signed [63:0] d_ext, acc_step;
	logic               ovf_hit, tl_room, tl_room_f;
	logic               pend_cmp, pend_neg, int_go, id_go;
	logic               fresh, fresh_lex;
	bundle_t            b;

	assign accept   = push && !full;
	assign c        = char_item.ch;
	assign has_ch   = char_item.ch_valid && (c != 8'h00);
	assign end_item = char_item.clause_end || (char_item.ch_valid && (c == 8'h00));

	assign is_dig   = c inside {[CH_0:CH_9]};
	assign is_lower = c inside {[CH_LA:CH_LZ]};
	assign is_alp   = is_lower || (c inside {[CH_UA:CH_UZ]});
	assign is_idc   = is_alp || is_dig || (c == CH_US);
	assign is_sp    = (c == CH_SP) || (c inside {[CH_TAB:CH_CR]});
	assign is_op    = c inside {CH_EQ, CH_BANG, CH_GT, CH_LT, CH_MINUS};
	assign upc      = is_lower ? (c - 8'd32) : c;
	assign esc_c    = (c == CH_LN) ? CH_NL : ((c == CH_LTT) ? CH_TAB : c);

	assign tl_room   = tl_q < LEN_W'(TOKEN_MAX_LEN);
	assign tl_room_f = tl_f < LEN_W'(TOKEN_MAX_LEN);
	assign pend_cmp  = (c == CH_EQ) && (pend_q inside {CH_EQ, CH_BANG, CH_GT, CH_LT});
	assign pend_neg  = (pend_q == CH_MINUS) && is_dig;
	assign int_go    = is_dig && tl_room;
	assign id_go     = is_idc && tl_room;

	// Accumulate with the sign applied so the token end needs no negation.
	assign d_ext    = {60'd0, c[3:0]};
	assign acc_step = (acc_q <<< 3) + (acc_q <<< 1) + (neg_q ? -d_ext : d_ext);

	always_comb begin
		if (neg_q)
			ovf_hit = (c[3:0] <= 4'd8) ? (acc_q < -INT_T0) : (acc_q < -INT_T0M1);
		else
			ovf_hit = (c[3:0] <= 4'd7) ? (acc_q > INT_T0) : (acc_q > INT_T0M1);
	end

	// The byte opens a new token when the open one does not take it.
	always_comb begin
		case (mode_q)
			LEX_PEND:  fresh = !pend_cmp && !pend_neg;
			LEX_INT:   fresh = !int_go;
			LEX_IDENT: fresh = !id_go;
			LEX_STR:   fresh = 1'b0;
			LEX_ESC:   fresh = 1'b0;
			default:   fresh = 1'b1;
		endcase
	end

	assign fresh_lex = has_ch && fresh && !is_sp;

	// next state after the byte
	always_comb begin
		mode_f = mode_q;
		pend_f = pend_q;
		acc_f  = acc_q;
		neg_f  = neg_q;
		ovf_f  = ovf_q;
		tl_f   = tl_q;
		kwp_f  = kwp_q;
		if (has_ch) begin
			case (mode_q)
				LEX_PEND: begin
					mode_f = LEX_IDLE;
					pend_f = 8'h00;
					if (!pend_cmp && pend_neg) begin
						mode_f = LEX_INT;
						acc_f  = -d_ext;
						neg_f  = 1'b1;
						ovf_f  = 1'b0;
						tl_f   = LEN_W'(2);
					end
				end
				LEX_INT: begin
					if (int_go) begin
						if (!ovf_q) begin
							if (ovf_hit)
								ovf_f = 1'b1;
							else
								acc_f = acc_step;
						end
						tl_f = tl_q + LEN_W'(1);
					end else begin
						mode_f = LEX_IDLE;
					end
				end
				LEX_IDENT: begin
					if (id_go) begin
						if (tl_q == LEN_W'(1))
							kwp_f[15:8] = upc;
						else if (tl_q == LEN_W'(2))
							kwp_f[7:0] = upc;
						tl_f = tl_q + LEN_W'(1);
					end else begin
						mode_f = LEX_IDLE;
					end
				end
				LEX_STR: begin
					if (c == CH_DQ)
						mode_f = LEX_IDLE;
					else if (c == CH_BSL)
						mode_f = LEX_ESC;
					else if (tl_room)
						tl_f = tl_q + LEN_W'(1);
				end
				LEX_ESC: begin
					mode_f = LEX_STR;
					if (tl_room)
						tl_f = tl_q + LEN_W'(1);
				end
				default: begin
					mode_f = LEX_IDLE;
				end
			endcase
			if (fresh_lex) begin
				if (is_op) begin
					mode_f = LEX_PEND;
					pend_f = c;
				end else if (c == CH_DQ) begin
					mode_f = LEX_STR;
					tl_f   = '0;
				end else if (is_dig) begin
					mode_f = LEX_INT;
					acc_f  = d_ext;
					neg_f  = 1'b0;
					ovf_f  = 1'b0;
					tl_f   = LEN_W'(1);
				end else if (is_alp || c == CH_US) begin
					mode_f = LEX_IDENT;
					tl_f   = LEN_W'(1);
					kwp_f  = {upc, 16'h0000};
				end
			end
		end
	end

	// results of the item
	always_comb begin
		b = '0;
		if (has_ch) begin
			case (mode_q)
				LEX_PEND: begin
					if (pend_cmp)
						b = bput(b, tok_rec(cmp_kind(pend_q)));
					else if (!pend_neg)
						b = bput(b, flush_rec(pend_q));
				end
				LEX_INT: begin
					if (!int_go)
						b = bput(b, int_rec(acc_q, neg_q, ovf_q));
				end
				LEX_IDENT: begin
					if (id_go)
						b = bput(b, mk_rec(1'b1, KIND_IDENT, c, 64'sd0, 1'b0, 8'h00));
					else
						b = bput(b, ident_rec(tl_q, kwp_q));
				end
				LEX_STR: begin
					if (c == CH_DQ)
						b = bput(b, mk_rec(1'b0, KIND_STR, 8'h00, 64'sd0, 1'b0,
							len_sat(tl_q)));
					else if (c != CH_BSL && tl_room)
						b = bput(b, mk_rec(1'b1, KIND_STR, c, 64'sd0, 1'b0, 8'h00));
				end
				LEX_ESC: begin
					if (tl_room)
						b = bput(b, mk_rec(1'b1, KIND_STR, esc_c, 64'sd0, 1'b0, 8'h00));
				end
				default: begin
				end
			endcase
			if (fresh_lex) begin
				if (c == CH_LP)
					b = bput(b, tok_rec(KIND_LP));
				else if (c == CH_RP)
					b = bput(b, tok_rec(KIND_RP));
				else if (is_alp || c == CH_US)
					b = bput(b, mk_rec(1'b1, KIND_IDENT, c, 64'sd0, 1'b0, 8'h00));
				else if (!is_op && c != CH_DQ && !is_dig)
					b = bput(b, mk_rec(1'b0, KIND_ERR, c, 64'sd0, 1'b0, 8'h00));
			end
		end
		if (end_item) begin
			// flush the open token from the state left by the byte
			case (mode_f)
				LEX_PEND:  b = bput(b, flush_rec(pend_f));
				LEX_INT:   b = bput(b, int_rec(acc_f, neg_f, ovf_f));
				LEX_IDENT: b = bput(b, ident_rec(tl_f, kwp_f));
				LEX_ESC: begin
					if (tl_room_f) begin
						b = bput(b, mk_rec(1'b1, KIND_STR, CH_BSL, 64'sd0, 1'b0, 8'h00));
						b = bput(b, mk_rec(1'b0, KIND_STR, 8'h00, 64'sd0, 1'b0,
							len_sat(tl_f + LEN_W'(1))));
					end else begin
						b = bput(b, mk_rec(1'b0, KIND_STR, 8'h00, 64'sd0, 1'b0,
							len_sat(tl_f)));
					end
				end
				LEX_STR: begin
					b = bput(b, mk_rec(1'b0, KIND_STR, 8'h00, 64'sd0, 1'b0, len_sat(tl_f)));
				end
				default: begin
				end
			endcase
			b = bput(b, tok_rec(KIND_EOF));
		end
		if (b.cnt != '0)
			b.recs[REC_IDX_W'(b.cnt - CNT_W'(1))].last = 1'b1;
	end

	assign bq_push  = accept && (b.cnt != '0);
	assign bq_wdata = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LEX_IDLE;
			pend_q <= 8'h00;
			acc_q  <= 64'sd0;
			neg_q  <= 1'b0;
			ovf_q  <= 1'b0;
			tl_q   <= '0;
			kwp_q  <= 24'h000000;
		end else if (accept) begin
			if (end_item) begin
				mode_q <= LEX_IDLE;
				pend_q <= 8'h00;
				acc_q  <= 64'sd0;
				neg_q  <= 1'b0;
				ovf_q  <= 1'b0;
				tl_q   <= '0;
				kwp_q  <= 24'h000000;
			end else begin
				mode_q <= mode_f;
				pend_q <= pend_f;
				acc_q  <= acc_f;
				neg_q  <= neg_f;
				ovf_q  <= ovf_f;
				tl_q   <= tl_f;
				kwp_q  <= kwp_f;
			end
		end
	end

endmodule

`default_nettype wire

### src/fet_bundle_q.sv
`default_nettype none

module fet_bundle_q import fet_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire bundle_t wr_data,
	output logic         full,
	input  wire logic    rd_en,
	output bundle_t      rd_data,
	output logic         empty
);

	bundle_t               mem_q [BQ_DEPTH];
	logic [BQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [BQ_CNT_W-1:0]   count_q;
	logic                  do_wr, do_rd;

	assign full    = count_q == BQ_CNT_W'(BQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == BQ_PTR_W'(BQ_DEPTH - 1)) ? '0 :
					wr_ptr_q + BQ_PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == BQ_PTR_W'(BQ_DEPTH - 1)) ? '0 :
					rd_ptr_q + BQ_PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + BQ_CNT_W'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - BQ_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### src/fet_back.sv
`default_nettype none

module fet_back import fet_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t bq_data,
	input  wire logic    bq_empty,
	output logic         bq_pop,
	output logic         empty,
	input  wire logic    pop,
	output out_item_t    result
);

	logic [REC_IDX_W-1:0] sel_q;
	out_item_t            oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]  oq_wr_q, oq_rd_q;
	logic [OQ_CNT_W-1:0]  oq_cnt_q;
	logic                 take, last_rec, do_pop;

	// Move one record of the head bundle per cycle into the result queue while it has room.
	assign take     = !bq_empty && (oq_cnt_q != OQ_CNT_W'(OQ_DEPTH));
	assign last_rec = (CNT_W'(sel_q) + CNT_W'(1)) == bq_data.cnt;
	assign bq_pop   = take && last_rec;

	assign empty  = oq_cnt_q == '0;
	assign do_pop = pop && !empty;
	assign result = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (take)
			oq_mem_q[oq_wr_q] <= bq_data.recs[sel_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q    <= '0;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (take) begin
				sel_q   <= last_rec ? '0 : sel_q + REC_IDX_W'(1);
				oq_wr_q <= (oq_wr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 :
					oq_wr_q + OQ_PTR_W'(1);
			end
			if (do_pop)
				oq_rd_q <= (oq_rd_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 :
					oq_rd_q + OQ_PTR_W'(1);
			if (take && !do_pop)
				oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
			else if (do_pop && !take)
				oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### src/filter_expression_tokenizer.sv
// Streaming lexer for filter expressions, one source byte per input item.
// Input queue side: drive char_item and raise push; the item is taken at a
// clock edge with push high and full low. An item with clause_end set (or a
// zero byte) flushes the open token and ends with an EOF record.
// Result queue side: while empty is low the oldest record sits on result;
// raise pop to take it. Each item gives zero to four records, the final one
// marked by last; string and identifier text arrives as one record per byte
// before the token-end record.
// Path: the accepting edge writes the item's records as one bundle into the
// bundle queue, and from there they pass through the result queue to result.
// Throughput: while full is low, one item per cycle into the lexer stage, whose
// per-byte state update is the limit on the input side; records leave at one
// per cycle through the bundle queue and the result queue while the result
// queue has room.
// Stalling: with pop low the result queue and then the two-entry bundle
// queue fill, and full rises; items with no records still pass while full
// is low. Reset clears the lexer state and both queues at once.
`default_nettype none

`include "assert_macros.svh"

module filter_expression_tokenizer import fet_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t char_item,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	logic    bq_push, bq_pop, bq_empty;
	bundle_t bq_wdata, bq_rdata;

	fet_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_item (char_item),
		.bq_push   (bq_push),
		.bq_wdata  (bq_wdata)
	);

	fet_bundle_q u_bundle_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bq_push),
		.wr_data (bq_wdata),
		.full    (full),
		.rd_en   (bq_pop),
		.rd_data (bq_rdata),
		.empty   (bq_empty)
	);

	fet_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.bq_data  (bq_rdata),
		.bq_empty (bq_empty),
		.bq_pop   (bq_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// a clause end always leaves at least its EOF record in the queue
	`ASSERT_IMPLY(a_end_writes_bundle, clk, arst_n, push && !full && char_item.clause_end, bq_push)
	// EOF closes the records of its item
	`ASSERT_IMPLY(a_eof_is_last, clk, arst_n, !empty && !result.is_text && result.kind == KIND_EOF, result.last)
	// saturation flag only on integer token ends
	`ASSERT_IMPLY(a_sat_only_int, clk, arst_n, !empty && result.int_saturated, !result.is_text && result.kind == KIND_INT)

endmodule

`default_nettype wire

### tb/tb_filter_expression_tokenizer.sv
`timescale 1ns / 1ps

module tb_filter_expression_tokenizer;
	import fet_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RX_LONG_HOLD   = 80;
	localparam int END_TAIL       = 20;
	localparam int RANDOM_ITEMS   = 20;
	localparam int QUIET_ITEMS    = 8;

	localparam logic [23:0] KW_AND = 24'h414E44;
	localparam logic [23:0] KW_OR  = 24'h4F5200;
	localparam logic [23:0] KW_NOT = 24'h4E4F54;

	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	in_item_t  char_item = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	filter_expression_tokenizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_item (char_item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lexer state mirrored on the testbench side.
	lex_mode_t   lx_mode;
	logic [7:0]  lx_pend;
	logic [63:0] lx_mag;
	logic        lx_neg;
	logic        lx_ovf;
	int          lx_len;
	logic [23:0] lx_prefix;

	out_item_t step_recs[$];
	out_item_t expected_recs[$];
	out_item_t want;

	int  mismatches = 0;
	int  items_sent = 0;
	int  idle_cycles = 0;
	int  rx_wait = 0;
	bit  tx_idle_en = 1'b0;
	bit  rx_idle_en = 1'b0;
	bit  rx_hold_req = 1'b0;

	string op_list[8] = '{"(", ")", "==", "!=", ">", ">=", "<", "<="};
	string kw_list[3] = '{"and", "or", "not"};

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	task automatic lex_clear();
		lx_mode   = LEX_IDLE;
		lx_pend   = '0;
		lx_mag    = '0;
		lx_neg    = 1'b0;
		lx_ovf    = 1'b0;
		lx_len    = 0;
		lx_prefix = '0;
	endtask

	task automatic add_rec(input logic txt, input logic [3:0] k, input logic [7:0] b,
			input logic [63:0] v, input logic sat, input int len);
		out_item_t r;
		if (step_recs.size() >= MAX_RECS) return;
		r.is_text       = txt;
		r.kind          = k;
		r.text_byte     = b;
		r.int_value     = v;
		r.int_saturated = sat;
		r.text_length   = (len > 255) ? 8'd255 : 8'(len);
		r.last          = 1'b0;
		step_recs.push_back(r);
	endtask

	task automatic add_token(input logic [3:0] k);
		add_rec(1'b0, k, 8'd0, 64'd0, 1'b0, 0);
	endtask

	task automatic ident_byte(input logic [7:0] c);
		logic [7:0] u;
		u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
		if (lx_len < 3)
			lx_prefix |= 24'(u) << (8 * (2 - lx_len));
		lx_len++;
		add_rec(1'b1, KIND_IDENT, c, 64'd0, 1'b0, 0);
	endtask

	task automatic int_digit(input logic [7:0] c);
		logic [63:0] d;
		logic [63:0] lim;
		d = 64'(c - "0");
		lim = lx_neg ? NEG_LIMIT : POS_LIMIT;
		if (!lx_ovf) begin
			if (lx_mag > (lim - d) / 64'd10)
				lx_ovf = 1'b1;
			else
				lx_mag = lx_mag * 64'd10 + d;
		end
		lx_len++;
	endtask

	task automatic start_int(input logic neg, input logic [7:0] c);
		lx_mode = LEX_INT;
		lx_mag  = '0;
		lx_neg  = neg;
		lx_ovf  = 1'b0;
		lx_len  = neg ? 1 : 0;
		int_digit(c);
	endtask

	task automatic end_int();
		logic [63:0] v;
		if (lx_ovf)
			v = lx_neg ? NEG_LIMIT : POS_LIMIT;
		else
			v = lx_neg ? (64'd0 - lx_mag) : lx_mag;
		add_rec(1'b0, KIND_INT, 8'd0, v, lx_ovf, 0);
	endtask

	task automatic end_ident();
		logic [3:0] k;
		k = KIND_IDENT;
		if (lx_len == 3 && lx_prefix == KW_AND)
			k = KIND_AND;
		else if (lx_len == 2 && lx_prefix == KW_OR)
			k = KIND_OR;
		else if (lx_len == 3 && lx_prefix == KW_NOT)
			k = KIND_NOT;
		add_rec(1'b0, k, 8'd0, 64'd0, 1'b0, lx_len);
	endtask

	task automatic flush_pend(input logic [7:0] p);
		if (p == ">")
			add_token(KIND_GT);
		else if (p == "<")
			add_token(KIND_LT);
		else
			add_rec(1'b0, KIND_ERR, p, 64'd0, 1'b0, 0);
	endtask

	task automatic str_byte(input logic [7:0] c);
		if (lx_len < TOKEN_MAX_LEN) begin
			lx_len++;
			add_rec(1'b1, KIND_STR, c, 64'd0, 1'b0, 0);
		end
	endtask

	task automatic lex_feed(input logic [7:0] c);
		logic [7:0] p;
		bit fresh;
		fresh = 1'b1;
		case (lx_mode)
			LEX_PEND: begin
				p = lx_pend;
				lx_mode = LEX_IDLE;
				lx_pend = '0;
				fresh = 1'b0;
				if (c == "=" && p == "=")
					add_token(KIND_EQ);
				else if (c == "=" && p == "!")
					add_token(KIND_NE);
				else if (c == "=" && p == ">")
					add_token(KIND_GE);
				else if (c == "=" && p == "<")
					add_token(KIND_LE);
				else if (p == "-" && is_digit(c))
					start_int(1'b1, c);
				else begin
					flush_pend(p);
					fresh = 1'b1;
				end
			end
			LEX_INT: begin
				if (is_digit(c) && lx_len < TOKEN_MAX_LEN) begin
					int_digit(c);
					fresh = 1'b0;
				end else begin
					end_int();
					lx_mode = LEX_IDLE;
				end
			end
			LEX_IDENT: begin
				if ((is_alpha(c) || is_digit(c) || c == "_") && lx_len < TOKEN_MAX_LEN) begin
					ident_byte(c);
					fresh = 1'b0;
				end else begin
					end_ident();
					lx_mode = LEX_IDLE;
				end
			end
			LEX_STR: begin
				fresh = 1'b0;
				if (c == "\"") begin
					add_rec(1'b0, KIND_STR, 8'd0, 64'd0, 1'b0, lx_len);
					lx_mode = LEX_IDLE;
				end else if (c == "\\") begin
					lx_mode = LEX_ESC;
				end else begin
					str_byte(c);
				end
			end
			LEX_ESC: begin
				fresh = 1'b0;
				lx_mode = LEX_STR;
				str_byte(c == "n" ? 8'd10 : (c == "t" ? 8'd9 : c));
			end
			default: lx_mode = LEX_IDLE;
		endcase

		if (fresh && !is_space(c)) begin
			if (c == "=" || c == "!" || c == ">" || c == "<" || c == "-") begin
				lx_mode = LEX_PEND;
				lx_pend = c;
			end else if (c == "(") begin
				add_token(KIND_LP);
			end else if (c == ")") begin
				add_token(KIND_RP);
			end else if (c == "\"") begin
				lx_mode = LEX_STR;
				lx_len = 0;
			end else if (is_digit(c)) begin
				start_int(1'b0, c);
			end else if (is_alpha(c) || c == "_") begin
				lx_mode = LEX_IDENT;
				lx_len = 0;
				lx_prefix = '0;
				ident_byte(c);
			end else begin
				add_rec(1'b0, KIND_ERR, c, 64'd0, 1'b0, 0);
			end
		end
	endtask

	task automatic lex_step(input in_item_t it);
		bit endc;
		step_recs.delete();
		endc = it.clause_end;
		if (it.ch_valid && it.ch != 8'd0)
			lex_feed(it.ch);
		if (it.ch_valid && it.ch == 8'd0)
			endc = 1'b1;
		if (endc) begin
			case (lx_mode)
				LEX_PEND:  flush_pend(lx_pend);
				LEX_INT:   end_int();
				LEX_IDENT: end_ident();
				LEX_ESC: begin
					// keep the dangling backslash as a literal byte
					str_byte("\\");
					add_rec(1'b0, KIND_STR, 8'd0, 64'd0, 1'b0, lx_len);
				end
				LEX_STR:   add_rec(1'b0, KIND_STR, 8'd0, 64'd0, 1'b0, lx_len);
				default: ;
			endcase
			add_token(KIND_EOF);
			lex_clear();
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size() - 1].last = 1'b1;
		foreach (step_recs[i])
			expected_recs.push_back(step_recs[i]);
	endtask

	// Predict on every accepted item.
	always @(posedge clk) begin
		if (arst_n && push && !full)
			lex_step(char_item);
	end

	// Compare every accepted record against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_recs.size() == 0) begin
				$error("unexpected record: kind %0d text_byte %0h", result.kind,
					result.text_byte);
				mismatches++;
			end else begin
				want = expected_recs.pop_front();
				if (result.is_text !== want.is_text) begin
					$error("is_text: expected %0d, got %0d", want.is_text, result.is_text);
					mismatches++;
				end
				if (result.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result.kind);
					mismatches++;
				end
				if (result.text_byte !== want.text_byte) begin
					$error("text_byte: expected %0h, got %0h", want.text_byte,
						result.text_byte);
					mismatches++;
				end
				if (result.int_value !== want.int_value) begin
					$error("int_value: expected %0d, got %0d", want.int_value,
						result.int_value);
					mismatches++;
				end
				if (result.int_saturated !== want.int_saturated) begin
					$error("int_saturated: expected %0d, got %0d", want.int_saturated,
						result.int_saturated);
					mismatches++;
				end
				if (result.text_length !== want.text_length) begin
					$error("text_length: expected %0d, got %0d", want.text_length,
						result.text_length);
					mismatches++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					mismatches++;
				end
			end
		end
	end

	// Consumer side: random pop bursts, plus one long hold on request.
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_wait = RX_LONG_HOLD;
		end
		if (rx_wait > 0) begin
			rx_wait--;
			pop <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_wait = $urandom_range(1, 14) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic in_item_t mk_item(input logic [7:0] c, input logic v, input logic e);
		in_item_t it;
		it.ch = c;
		it.ch_valid = v;
		it.clause_end = e;
		return it;
	endfunction

	function automatic logic [7:0] rand_ident_char(input bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26)
			return "a" + 8'(r);
		if (r < 52)
			return "A" + 8'(r - 26);
		if (r == 52)
			return "_";
		return "0" + 8'(r - 53);
	endfunction

	function automatic logic [7:0] rand_str_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == "\"" || c == "\\");
		return c;
	endfunction

	// Offer one item; returns at the edge that takes it.
	task automatic send_item(input in_item_t it);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		push <= 1'b1;
		char_item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (it.ch_valid || it.clause_end)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(mk_item(s[i], 1'b1, 1'b0));
	endtask

	task automatic end_clause();
		send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_recs.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_operators();
		send_text("( ) == != > >= < <= ><");
		end_clause();
		send_text("=a !b -c -7 @");
		send_item(mk_item(8'hFF, 1'b1, 1'b0));
		send_item(mk_item(8'hA5, 1'b0, 1'b0));
		send_item(mk_item(">", 1'b1, 1'b1));
		send_text("x");
		send_item(mk_item("-", 1'b1, 1'b1));
		send_text("<");
		send_item(mk_item(8'h00, 1'b1, 1'b0));
	endtask

	task automatic test_keywords();
		send_text("and Or NOT anD ANDx OR1 no _a9 not(");
		end_clause();
	endtask

	task automatic test_strings();
		send_text("\"a\\n\\t\\\\\\\"b\" \"\"");
		end_clause();
		send_text("\"ab");
		end_clause();
		send_text("\"x\\");
		end_clause();
	endtask

	task automatic test_integers();
		send_text("9223372036854775807 -9223372036854775809 -0 42");
		send_item(mk_item(")", 1'b1, 1'b1));
	endtask

	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		repeat (12)
			send_text("(");
		end_clause();
		wait_drained();
	endtask

	task automatic test_random();
		int first;
		int n;
		logic [7:0] c;
		string kw;
		first = items_sent;
		while (items_sent < first + RANDOM_ITEMS) begin
			if (items_sent >= first + RANDOM_ITEMS - QUIET_ITEMS) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			case ($urandom_range(0, 9))
				0: send_item(mk_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
					$urandom_range(0, 7) == 0));
				1: begin
					case ($urandom_range(0, 2))
						0: begin
							send_text("\"");
							repeat ($urandom_range(0, 3))
								send_item(mk_item(rand_str_char(), 1'b1, 1'b0));
						end
						1: begin
							c = ($urandom_range(0, 1) == 0) ? "=" : "!";
							if ($urandom_range(0, 2) == 0)
								c = "-";
							send_item(mk_item(c, 1'b1, 1'b0));
						end
						default: send_text("\"q\\");
					endcase
					end_clause();
				end
				2, 3: send_text(op_list[$urandom_range(0, 7)]);
				4: begin
					kw = kw_list[$urandom_range(0, 2)];
					for (int i = 0; i < kw.len(); i++) begin
						c = kw[i];
						if ($urandom_range(0, 1) == 0)
							c = c - 8'h20;
						send_item(mk_item(c, 1'b1, 1'b0));
					end
				end
				5, 6: begin
					send_item(mk_item(rand_ident_char(1'b1), 1'b1, 1'b0));
					repeat ($urandom_range(0, 7))
						send_item(mk_item(rand_ident_char(1'b0), 1'b1, 1'b0));
				end
				7, 8: begin
					if ($urandom_range(0, 2) == 0)
						send_text("-");
					n = $urandom_range(1, 20);
					repeat (n)
						send_item(mk_item("0" + 8'($urandom_range(0, 9)), 1'b1, 1'b0));
				end
				default: begin
					send_text("\"");
					repeat ($urandom_range(0, 10)) begin
						if ($urandom_range(0, 4) == 0) begin
							send_text("\\");
							c = ($urandom_range(0, 1) == 0) ? "n" : "t";
							if ($urandom_range(0, 2) == 0)
								c = 8'($urandom_range(1, 255));
							send_item(mk_item(c, 1'b1, 1'b0));
						end else begin
							send_item(mk_item(rand_str_char(), 1'b1, 1'b0));
						end
					end
					send_text("\"");
				end
			endcase
			case ($urandom_range(0, 3))
				0: send_text(" ");
				1: send_text("\t");
				2: send_text("\n");
				default: ;
			endcase
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0: end_clause();
					1: send_item(mk_item(8'h00, 1'b1, 1'b0));
					default: send_item(mk_item(")", 1'b1, 1'b1));
				endcase
			end
		end
	endtask

	initial begin
		lex_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;

		test_operators();
		test_keywords();
		test_strings();
		test_integers();
		test_backpressure();
		test_random();

		push <= 1'b0;
		while (expected_recs.size() != 0)
			@(posedge clk);
		repeat (END_TAIL) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/fet_pkg.sv
src/fet_front.sv
src/fet_bundle_q.sv
src/fet_back.sv
src/filter_expression_tokenizer.sv
tb/tb_filter_expression_tokenizer.sv
